FILE: hdl/mlfc_pkg.sv
// Package for the M-Bus long frame checker: frame constants, verdict codes
// and the result item type shared by the front end, the queue and the top level.
// No dependencies.
package mlfc_pkg;

   // Frame bytes
   localparam logic [7:0] LONG_START = 8'h68;
   localparam logic [7:0] STOP_BYTE  = 8'h16;

   // Size limits
   localparam int unsigned MIN_SIZE      = 9;
   localparam int unsigned SIZE_OVERHEAD = 6;
   localparam int unsigned MIN_L         = 3;
   localparam int unsigned FIRST_DATA    = 7;   // index of first application byte
   localparam int unsigned FIRST_SUM     = 4;   // index of first checksummed byte

   localparam int unsigned INDEX_W   = 9;
   localparam logic [INDEX_W-1:0] INDEX_MAX = '1;

   // Default depth of the queue between front end and output
   localparam int unsigned QUEUE_DEPTH = 4;

   // Field widths
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned STATUS_W = 3;
   localparam int unsigned RSP_DATA_W = 48;   // 43 field bits padded to bytes

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 3'd0,
      STATUS_SHORT     = 3'd1,
      STATUS_BAD_FRAME = 3'd2,
      STATUS_LEN_MISM  = 3'd3,
      STATUS_L_LOW     = 3'd4,
      STATUS_CSUM_BAD  = 3'd5
   } status_type;

   // One result item as it travels through the queue
   typedef struct packed {
      logic              is_verdict;
      logic [BYTE_W-1:0] payload_byte;
      status_type        status;
      logic [BYTE_W-1:0] control_field;
      logic [BYTE_W-1:0] address_field;
      logic [BYTE_W-1:0] ci_field;
      logic [BYTE_W-1:0] app_length;
   } rsp_item_type;

endpackage

FILE: hdl/mlfc_front.sv
// Front end of the M-Bus long frame checker: takes frame bytes, tracks the
// header, length and checksum, and classifies each byte into a result item.
// Depends on mlfc_pkg.
module mlfc_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [7:0]            rx_byte,
   input  logic                  frame_end,
   output logic                  push_valid,
   output mlfc_pkg::rsp_item_type push_item,
   input  logic                  push_ready
);
   import mlfc_pkg::*;

   logic [INDEX_W-1:0] byte_index_ff, byte_index_in;
   logic [BYTE_W-1:0]  length_ff, length_in;
   logic               header_good_ff, header_good_in;
   logic [BYTE_W-1:0]  control_ff, control_in;
   logic [BYTE_W-1:0]  address_ff, address_in;
   logic [BYTE_W-1:0]  ci_ff, ci_in;
   logic [BYTE_W-1:0]  sum_ff, sum_in;
   logic [BYTE_W-1:0]  prev_ff, prev_in;

   logic               accept;
   logic [INDEX_W:0]   idx_ext;
   logic [INDEX_W:0]   last_sum_idx;   // L + 3
   logic [INDEX_W:0]   expected_last;  // L + 5, index of stop byte
   logic               in_sum_range;
   logic               in_data_range;
   status_type         status;

   assign in_ready = push_ready;
   assign accept   = in_valid && in_ready;

   assign idx_ext       = {1'b0, byte_index_ff};
   assign last_sum_idx  = {2'b00, length_ff} + (INDEX_W+1)'(MIN_L);
   assign expected_last = {2'b00, length_ff} + (INDEX_W+1)'(SIZE_OVERHEAD - 1);
   assign in_sum_range  = (idx_ext >= (INDEX_W+1)'(FIRST_SUM)) && (idx_ext <= last_sum_idx);
   assign in_data_range = (idx_ext >= (INDEX_W+1)'(FIRST_DATA)) && (idx_ext <= last_sum_idx);

   // Verdict checks in priority order
   always_comb begin
      if (idx_ext < (INDEX_W+1)'(MIN_SIZE - 1)) begin
         status = STATUS_SHORT;
      end else if (!header_good_ff || rx_byte != STOP_BYTE) begin
         status = STATUS_BAD_FRAME;
      end else if (idx_ext != expected_last) begin
         status = STATUS_LEN_MISM;
      end else if (length_ff < BYTE_W'(MIN_L)) begin
         status = STATUS_L_LOW;
      end else if (prev_ff != sum_ff) begin
         status = STATUS_CSUM_BAD;
      end else begin
         status = STATUS_OK;
      end
   end

   // Result item for this byte
   always_comb begin
      push_item = '0;
      push_valid = 1'b0;
      if (frame_end) begin
         push_valid              = accept;
         push_item.is_verdict    = 1'b1;
         push_item.status        = status;
         push_item.control_field = control_ff;
         push_item.address_field = address_ff;
         push_item.ci_field      = ci_ff;
         push_item.app_length    = (length_ff >= BYTE_W'(MIN_L)) ?
                                   length_ff - BYTE_W'(MIN_L) : '0;
      end else begin
         push_valid             = accept && in_data_range && header_good_ff;
         push_item.payload_byte = rx_byte;
      end
   end

   // Frame state update
   always_comb begin
      byte_index_in  = byte_index_ff;
      length_in      = length_ff;
      header_good_in = header_good_ff;
      control_in     = control_ff;
      address_in     = address_ff;
      ci_in          = ci_ff;
      sum_in         = sum_ff;
      prev_in        = prev_ff;
      if (accept) begin
         if (frame_end) begin
            // back to the reset state for the next frame
            byte_index_in  = '0;
            length_in      = '0;
            header_good_in = 1'b1;
            control_in     = '0;
            address_in     = '0;
            ci_in          = '0;
            sum_in         = '0;
            prev_in        = '0;
         end else begin
            case (byte_index_ff)
               INDEX_W'(0): begin
                  if (rx_byte != LONG_START) header_good_in = 1'b0;
               end
               INDEX_W'(1): length_in = rx_byte;
               INDEX_W'(2): begin
                  if (rx_byte != length_ff) header_good_in = 1'b0;
               end
               INDEX_W'(3): begin
                  if (rx_byte != LONG_START) header_good_in = 1'b0;
               end
               INDEX_W'(4): control_in = rx_byte;
               INDEX_W'(5): address_in = rx_byte;
               INDEX_W'(6): ci_in      = rx_byte;
               default: ;
            endcase
            if (in_sum_range) sum_in = sum_ff + rx_byte;
            prev_in = rx_byte;
            // saturate on over-long frames
            if (byte_index_ff != INDEX_MAX) byte_index_in = byte_index_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff  <= '0;
         length_ff      <= '0;
         header_good_ff <= 1'b1;
         control_ff     <= '0;
         address_ff     <= '0;
         ci_ff          <= '0;
         sum_ff         <= '0;
         prev_ff        <= '0;
      end else begin
         byte_index_ff  <= byte_index_in;
         length_ff      <= length_in;
         header_good_ff <= header_good_in;
         control_ff     <= control_in;
         address_ff     <= address_in;
         ci_ff          <= ci_in;
         sum_ff         <= sum_in;
         prev_ff        <= prev_in;
      end
   end

endmodule

FILE: hdl/mlfc_queue.sv
// Short result queue between the front end and the result port; its head
// drives the result port directly. Depends on mlfc_pkg.
module mlfc_queue #(
   parameter int unsigned DEPTH = mlfc_pkg::QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   input  mlfc_pkg::rsp_item_type push_item,
   output logic                   push_ready,
   output logic                   head_valid,
   output mlfc_pkg::rsp_item_type head_item,
   input  logic                   pop_ready
);
   import mlfc_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   rsp_item_type      entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = head_valid && pop_ready;

   // Pointer and fill level update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage: payload only, no reset
   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_item;
   end

endmodule

FILE: hdl/mbus_long_frame_checker.sv
// Top level of the M-Bus long frame checker: front end classifier feeding a
// short result queue. Depends on mlfc_pkg, mlfc_front and mlfc_queue.
//
//   channel | dir | handshake               | contents
//   req     | in  | req_tvalid / req_tready | tdata: rx_byte, tlast: frame_end
//   rsp     | out | rsp_tvalid / rsp_tready | tdata: result fields, tuser: is_verdict
//
// One request per cycle while the queue has room; rsp shows the queue head.
// The front end updates all frame state in the cycle a byte is accepted.
// req_tready falls only when the result queue (QUEUE_DEPTH entries) is full.
// Synchronous active-high reset clears the frame state and empties the queue.
module mbus_long_frame_checker #(
   parameter int unsigned QUEUE_DEPTH = mlfc_pkg::QUEUE_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,   // [7:0] rx_byte
   input  logic                            req_tlast,   // frame_end
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [7:0] payload_byte, [10:8] status, [18:11] control_field,
   // [26:19] address_field, [34:27] ci_field, [42:35] app_length, [47:43] zero
   output logic [mlfc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                            rsp_tuser    // is_verdict
);
   import mlfc_pkg::*;

   rsp_item_type push_item, head_item;
   logic         push_valid, push_ready;

   mlfc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .rx_byte    (req_tdata),
      .frame_end  (req_tlast),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready)
   );

   mlfc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready),
      .head_valid (rsp_tvalid),
      .head_item  (head_item),
      .pop_ready  (rsp_tready)
   );

   // Pack the result fields, lowest field first
   assign rsp_tuser = head_item.is_verdict;
   assign rsp_tdata = {5'b00000,
                       head_item.app_length,
                       head_item.ci_field,
                       head_item.address_field,
                       head_item.control_field,
                       head_item.status,
                       head_item.payload_byte};

endmodule
